// ===== rtl/core/ghh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ghh_pkg
// Shared types and constants of the heading-hold steering unit.
// ----------------------------------------------------------------------------
package ghh_pkg;

  localparam int COUNT_BITS = 16;
  localparam int SUM_BITS   = COUNT_BITS + 16;
  localparam int QDEPTH     = 2;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_HEADING = 3'd1,
    MODE_FIX     = 3'd2,
    MODE_SENSOR  = 3'd3,
    MODE_START   = 3'd4,
    MODE_STOP    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_DRIVE   = 2'd1,
    PH_AVERAGE = 2'd2,
    PH_CONTROL = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_GAIN   = 3'd0,
    REG_DDELAY = 3'd1,
    REG_ATICKS = 3'd2,
    REG_SPEED  = 3'd3,
    REG_LIMIT  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_EXEC,
    BS_DIV,
    BS_MUL,
    BS_EMIT
  } bstate_t;

  // classified request handed from front to back
  typedef struct packed {
    mode_t       mode;
    logic [15:0] heading;
    logic [3:0]  fix;
    logic        halt;
  } cmd_t;

  typedef struct packed {
    logic signed [11:0] speed_cmd;
    logic signed [11:0] turn_cmd;
    logic [1:0]         phase;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/ghh_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ghh_in_if / ghh_out_if / ghh_cfg_if
// Valid/ready channels of the steering unit.
// ----------------------------------------------------------------------------
interface ghh_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [16:0] heading_cdeg;
  logic [3:0]  fix_quality;
  logic [7:0]  sensor_bits;
  modport source (output valid, mode, heading_cdeg, fix_quality, sensor_bits,
                  input ready);
  modport sink (input valid, mode, heading_cdeg, fix_quality, sensor_bits,
                output ready);
endinterface

interface ghh_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] speed_cmd;
  logic signed [11:0] turn_cmd;
  logic [1:0]         phase;
  modport source (output valid, speed_cmd, turn_cmd, phase, input ready);
  modport sink (input valid, speed_cmd, turn_cmd, phase, output ready);
endinterface

interface ghh_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gps_heading_hold_steering_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gps_heading_hold_steering_unit
// Event-driven straight-line heading-hold steering controller.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   in_ch    in   mode, heading_cdeg, fix_quality, sensor_bits
//   out_ch   out  speed_cmd, turn_cmd, phase
//   cfg      in   index, data
// A request passes the execute state of the back end; a heading sample during
// averaging then waits in the divide state for the serial divider; a control
// tick adds the multiply and emit states. A two-entry queue decouples
// acceptance from execution. Synchronous reset restores register defaults; no
// clearing pass. A stalled result holds the back end until taken.
module gps_heading_hold_steering_unit (
  input  wire        clk,
  input  wire        rst,
  ghh_in_if.sink     in_ch,
  ghh_out_if.source  out_ch,
  ghh_cfg_if.sink    cfg
);

  ghh_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  ghh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  ghh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cfg       (cfg),
    .out_ch    (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_out_phase_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.phase == ghh_pkg::PH_IDLE) |-> out_ch.speed_cmd == 12'sd0)
    else $error("idle result with nonzero speed");
  a_no_pop_when_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_ready) |-> !out_ch.valid)
    else $error("back end took command while result pending");
  a_turn_zero_outside_control: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.phase != ghh_pkg::PH_CONTROL) |-> out_ch.turn_cmd == 12'sd0)
    else $error("turn command outside control");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ghh_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ghh_front
// Accepts requests, normalizes the heading and queues classified commands.
// ----------------------------------------------------------------------------
module ghh_front (
  input  wire            clk,
  input  wire            rst,
  ghh_in_if.sink         in_ch,
  output ghh_pkg::cmd_t  cmd,
  output logic           cmd_valid,
  input  wire            cmd_ready
);

  ghh_pkg::cmd_t       q [ghh_pkg::QDEPTH];
  logic                wptr;
  logic                rptr;
  logic [1:0]          count;
  ghh_pkg::cmd_t       c;
  logic [16:0]         hsat;
  logic [16:0]         hred;
  logic                push;
  logic                pop;

  always_comb begin
    hsat = (in_ch.heading_cdeg > 17'd71999) ? 17'd71999 : in_ch.heading_cdeg;
    hred = (hsat > 17'd36000) ? hsat - 17'd36000 : hsat;
    c.mode    = ghh_pkg::mode_t'(in_ch.mode);
    c.heading = hred[15:0];
    c.fix     = in_ch.fix_quality;
    c.halt    = in_ch.sensor_bits[2] | in_ch.sensor_bits[1];
  end

  assign in_ch.ready = (count != 2'(ghh_pkg::QDEPTH));
  assign push        = in_ch.valid & in_ch.ready;
  assign cmd_valid   = (count != 2'd0);
  assign pop         = cmd_valid & cmd_ready;
  assign cmd         = q[rptr];

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ghh_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ghh_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ghh_divider (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  input  wire  [ghh_pkg::SUM_BITS+1:0]      num,
  input  wire  [ghh_pkg::COUNT_BITS+1:0]    den,
  output logic                              done,
  output logic [ghh_pkg::SUM_BITS+1:0]      quo
);

  localparam int NB = ghh_pkg::SUM_BITS + 2;
  localparam int DB = ghh_pkg::COUNT_BITS + 2;
  localparam int CB = $clog2(NB + 1);

  logic [NB-1:0] n;
  logic [DB-1:0] d;
  logic [DB:0]   rem;
  logic [CB-1:0] cnt;
  logic          busy;
  logic [DB:0]   trial;

  assign trial = {rem[DB-1:0], n[NB-1]};
  assign quo   = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CB'(NB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= num;
      d   <= den;
      rem <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        n   <= {n[NB-2:0], 1'b1};
      end else begin
        rem <= trial;
        n   <= {n[NB-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ghh_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ghh_back
// Executes queued commands: phases, timers, heading average, turn term.
// ----------------------------------------------------------------------------
module ghh_back (
  input  wire            clk,
  input  wire            rst,
  input  ghh_pkg::cmd_t  cmd,
  input  wire            cmd_valid,
  output logic           cmd_ready,
  ghh_cfg_if.sink        cfg,
  ghh_out_if.source      out_ch
);

  localparam int CBW = ghh_pkg::COUNT_BITS;
  localparam int SBW = ghh_pkg::SUM_BITS;

  // configuration
  logic [15:0]        gain;
  logic [15:0]        ddelay;
  logic [15:0]        aticks;
  logic signed [11:0] dspeed;
  logic [10:0]        tlimit;

  // state
  ghh_pkg::phase_t    phase_reg;
  ghh_pkg::bstate_t   bs;
  ghh_pkg::bstate_t   bs_next;
  logic               start_pending;
  logic               averaging_on;
  logic [3:0]         fix_reg;
  logic [15:0]        latest_heading;
  logic [15:0]        anchor_heading;
  logic signed [SBW-1:0] diff_sum;
  logic [CBW-1:0]     sample_count;
  logic [15:0]        average_heading;
  logic [15:0]        reference_heading;
  logic [15:0]        drive_timer;
  logic [15:0]        average_timer;
  ghh_pkg::cmd_t      cur;
  logic signed [32:0] product;

  // output register
  ghh_pkg::result_t   res;
  logic               out_valid;

  // divider
  logic               div_start;
  logic               div_done;
  logic [SBW+1:0]     div_num;
  logic [CBW+1:0]     div_den;
  logic [SBW+1:0]     div_quo;

  // execution helpers
  logic signed [17:0] dwrap;
  logic [15:0]        anc_eff;
  logic signed [SBW-1:0] sum_new;
  logic [SBW-1:0]     sum_mag;
  logic signed [17:0] err;
  logic [16:0]        err_mag;
  logic [32:0]        pmag;
  logic [16:0]        wmag;
  logic signed [17:0] avg;
  logic signed [17:0] turn_w;
  logic               drive_due;
  logic               avg_due;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= 16'd2684;
      ddelay <= 16'd400;
      aticks <= 16'd400;
      dspeed <= 12'sd307;
      tlimit <= 11'd1024;
    end else if (cfg.valid) begin
      case (ghh_pkg::reg_idx_t'(cfg.index))
        ghh_pkg::REG_GAIN:   gain   <= cfg.data;
        ghh_pkg::REG_DDELAY: ddelay <= cfg.data;
        ghh_pkg::REG_ATICKS: aticks <= cfg.data;
        ghh_pkg::REG_SPEED:  dspeed <= cfg.data[11:0];
        ghh_pkg::REG_LIMIT:  tlimit <= cfg.data[10:0];
        default: ;
      endcase
    end
  end

  ghh_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_ch.valid     = out_valid;
  assign out_ch.speed_cmd = res.speed_cmd;
  assign out_ch.turn_cmd  = res.turn_cmd;
  assign out_ch.phase     = res.phase;

  always_comb begin
    // timers compared after the saturating increment of this tick
    drive_due = (drive_timer + 17'd1) > ({1'b0, ddelay} + 17'(drive_timer == 16'hFFFF));
    avg_due   = (average_timer + 17'd1) >
                ({1'b0, aticks} + 17'(average_timer == 16'hFFFF));

    anc_eff = (sample_count == '0) ? cur.heading : anchor_heading;
    dwrap   = $signed({2'b00, anc_eff}) - $signed({2'b00, cur.heading});
    if (dwrap > 18'sd18000) dwrap = dwrap - 18'sd36000;
    else if (dwrap <= -18'sd18000) dwrap = dwrap + 18'sd36000;
    sum_new = diff_sum + SBW'(dwrap);
    sum_mag = sum_new[SBW-1] ? SBW'(-sum_new) : SBW'(sum_new);
    div_num = {1'b0, sum_mag, 1'b0} + {{(SBW-CBW+2){1'b0}}, sample_count + 1'b1};
    div_den = {1'b0, sample_count + 1'b1, 1'b0};

    err = $signed({2'b00, reference_heading}) - $signed({2'b00, latest_heading});
    if (err < -18'sd18000) err = err + 18'sd36000;
    else if (err > 18'sd18000) err = err - 18'sd36000;
    err_mag = err[17] ? 17'(-err) : 17'(err);

    pmag = product[32] ? 33'(-product) : 33'(product);
    pmag = pmag + 33'd32768;
    wmag = (pmag[32:16] > {6'd0, tlimit}) ? {6'd0, tlimit} : pmag[32:16];
    // negated term: a negative error steers positive
    turn_w = err[17] ? $signed({1'b0, wmag}) : -$signed({1'b0, wmag});

    avg = diff_sum[SBW-1] ? $signed({2'b00, anchor_heading}) + $signed(div_quo[17:0])
                          : $signed({2'b00, anchor_heading}) - $signed(div_quo[17:0]);
    if (avg > 18'sd36000) avg = avg - 18'sd36000;
    else if (avg < 0) avg = avg + 18'sd36000;
  end

  // next state
  always_comb begin
    bs_next = bs;
    case (bs)
      ghh_pkg::BS_IDLE: if (cmd_valid && !out_valid) bs_next = ghh_pkg::BS_EXEC;
      ghh_pkg::BS_EXEC: begin
        bs_next = ghh_pkg::BS_IDLE;
        if (cur.mode == ghh_pkg::MODE_HEADING && averaging_on &&
            sample_count != {CBW{1'b1}}) bs_next = ghh_pkg::BS_DIV;
      end
      ghh_pkg::BS_DIV: if (div_done) bs_next = ghh_pkg::BS_IDLE;
      ghh_pkg::BS_MUL: bs_next = ghh_pkg::BS_EMIT;
      ghh_pkg::BS_EMIT: if (!out_valid || out_ch.ready) bs_next = ghh_pkg::BS_IDLE;
      default: bs_next = ghh_pkg::BS_IDLE;
    endcase
    if (bs == ghh_pkg::BS_EXEC && cur.mode == ghh_pkg::MODE_TICK &&
        phase_reg == ghh_pkg::PH_CONTROL) bs_next = ghh_pkg::BS_MUL;
  end

  // outputs
  always_comb begin
    cmd_ready = (bs == ghh_pkg::BS_IDLE) && !out_valid;
    div_start = (bs == ghh_pkg::BS_EXEC) && (bs_next == ghh_pkg::BS_DIV);
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) cur <= cmd;
    product <= $signed({1'b0, gain}) * $signed({16'd0, err_mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bs                <= ghh_pkg::BS_IDLE;
      phase_reg         <= ghh_pkg::PH_IDLE;
      start_pending     <= 1'b0;
      averaging_on      <= 1'b0;
      fix_reg           <= '0;
      latest_heading    <= '0;
      anchor_heading    <= '0;
      diff_sum          <= '0;
      sample_count      <= '0;
      average_heading   <= '0;
      reference_heading <= '0;
      drive_timer       <= '0;
      average_timer     <= '0;
      out_valid         <= 1'b0;
    end else begin
      bs <= bs_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (bs)
        ghh_pkg::BS_EXEC: begin
          case (cur.mode)
            ghh_pkg::MODE_TICK: begin
              if (drive_timer != 16'hFFFF) drive_timer <= drive_timer + 1'b1;
              if (phase_reg == ghh_pkg::PH_DRIVE && drive_due && fix_reg == 4'd1) begin
                average_timer <= '0;
              end else if (average_timer != 16'hFFFF) begin
                average_timer <= average_timer + 1'b1;
              end
              case (phase_reg)
                ghh_pkg::PH_IDLE: if (start_pending) begin
                  start_pending <= 1'b0;
                  phase_reg     <= ghh_pkg::PH_DRIVE;
                end
                ghh_pkg::PH_DRIVE: begin
                  out_valid <= 1'b1;
                  if (drive_due) begin
                    if (fix_reg == 4'd1) begin
                      phase_reg     <= ghh_pkg::PH_AVERAGE;
                      averaging_on  <= 1'b1;
                      res <= '{dspeed, 12'sd0, ghh_pkg::PH_AVERAGE};
                    end else begin
                      phase_reg <= ghh_pkg::PH_IDLE;
                      res <= '{12'sd0, 12'sd0, ghh_pkg::PH_IDLE};
                    end
                  end else begin
                    res <= '{dspeed, 12'sd0, ghh_pkg::PH_DRIVE};
                  end
                end
                ghh_pkg::PH_AVERAGE: begin
                  if (avg_due) begin
                    phase_reg         <= ghh_pkg::PH_CONTROL;
                    reference_heading <= average_heading;
                  end
                end
                default: ;
              endcase
            end
            ghh_pkg::MODE_HEADING: begin
              latest_heading <= cur.heading;
              if (!averaging_on) begin
                sample_count    <= '0;
                diff_sum        <= '0;
                average_heading <= '0;
              end else if (sample_count != {CBW{1'b1}}) begin
                anchor_heading <= anc_eff;
                diff_sum       <= sum_new;
                sample_count   <= sample_count + 1'b1;
              end
            end
            ghh_pkg::MODE_FIX: fix_reg <= cur.fix;
            ghh_pkg::MODE_SENSOR: if (cur.halt) begin
              phase_reg <= ghh_pkg::PH_IDLE;
              out_valid <= 1'b1;
              res <= '{12'sd0, 12'sd0, ghh_pkg::PH_IDLE};
            end
            ghh_pkg::MODE_START: begin
              drive_timer   <= '0;
              start_pending <= 1'b1;
            end
            ghh_pkg::MODE_STOP: begin
              phase_reg    <= ghh_pkg::PH_IDLE;
              averaging_on <= 1'b0;
              out_valid    <= 1'b1;
              res <= '{12'sd0, 12'sd0, ghh_pkg::PH_IDLE};
            end
            default: ;
          endcase
        end
        ghh_pkg::BS_DIV: if (div_done) average_heading <= avg[15:0];
        ghh_pkg::BS_EMIT: if (!out_valid || out_ch.ready) begin
          out_valid <= 1'b1;
          res <= '{dspeed, turn_w[11:0], ghh_pkg::PH_CONTROL};
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_ghh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ghh_if
// Testbench note: the channel interfaces come from the RTL interface file.
// This file holds the typed request record that the stimulus uses.
// ----------------------------------------------------------------------------
package tb_ghh_pkg;
  import ghh_pkg::*;

  typedef struct {
    mode_t       mode;
    logic [16:0] heading;
    logic [3:0]  fix;
    logic [7:0]  sensor;
  } steer_req_t;
endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the heading-hold steering unit.
// Drives event requests with random gaps and result back-pressure. A local
// model of the steering controller predicts each command, and the scoreboard
// checks every result field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ghh_pkg::*;
  import tb_ghh_pkg::*;

  class steer_scoreboard;
    logic [15:0] gain, ddelay, aticks;
    logic signed [11:0] speed;
    logic [10:0] tlimit;
    phase_t ph;
    bit pend, avg_on;
    logic [3:0] fix;
    int latest, anchor, avg_hd, ref_hd;
    longint dsum;
    int unsigned cnt, dtmr, atmr;
    result_t cmd_q[$];
    int errors, results, steps;

    function void init();
      gain = 2684; ddelay = 400; aticks = 400; speed = 307; tlimit = 1024;
      ph = PH_IDLE; pend = 0; avg_on = 0; fix = 0;
      latest = 0; anchor = 0; avg_hd = 0; ref_hd = 0; dsum = 0;
      cnt = 0; dtmr = 0; atmr = 0;
      errors = 0; results = 0; steps = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] val);
      case (idx)
        REG_GAIN:   gain = val;
        REG_DDELAY: ddelay = val;
        REG_ATICKS: aticks = val;
        REG_SPEED:  speed = val[11:0];
        REG_LIMIT:  tlimit = val[10:0];
        default: ;
      endcase
    endfunction

    function void push(logic signed [11:0] s, logic signed [11:0] t, phase_t p);
      result_t r;
      r.speed_cmd = s;
      r.turn_cmd = t;
      r.phase = p;
      cmd_q.push_back(r);
    endfunction

    function int turn_for_error();
      int e, w, lim;
      longint p, mag;
      e = ref_hd - latest;
      lim = tlimit;
      if (e < -18000) e += 36000;
      else if (e > 18000) e -= 36000;
      p = longint'(gain) * e;
      mag = p < 0 ? -p : p;
      mag = (mag + 32768) >>> 16;
      w = int'(mag);
      if (p < 0) w = -w;
      if (w > lim) w = lim;
      else if (w < -lim) w = -lim;
      return -w;
    endfunction

    function void take_heading(logic [16:0] raw);
      int h, d;
      longint num, q;
      h = raw > 71999 ? 71999 : raw;
      if (h > 36000) h -= 36000;
      latest = h;
      if (!avg_on) begin
        cnt = 0; dsum = 0; avg_hd = 0;
        return;
      end
      if (cnt >= (1 << COUNT_BITS) - 1) return;
      if (cnt == 0) anchor = latest;
      d = anchor - latest;
      if (d > 18000) d -= 36000;
      else if (d <= -18000) d += 36000;
      dsum += d;
      cnt++;
      num = dsum < 0 ? -dsum : dsum;
      q = (2 * num + cnt) / (2 * longint'(cnt));
      avg_hd = anchor + (dsum < 0 ? int'(q) : -int'(q));
      if (avg_hd > 36000) avg_hd -= 36000;
      else if (avg_hd < 0) avg_hd += 36000;
    endfunction

    function void note_request(steer_req_t r);
      steps++;
      case (r.mode)
        MODE_TICK: begin
          if (dtmr < 65535) dtmr++;
          if (atmr < 65535) atmr++;
          case (ph)
            PH_IDLE: if (pend) begin
              pend = 0;
              ph = PH_DRIVE;
            end
            PH_DRIVE: begin
              if (dtmr > ddelay && fix != 1) begin
                ph = PH_IDLE;
                push(0, 0, PH_IDLE);
              end else begin
                if (dtmr > ddelay) begin
                  ph = PH_AVERAGE;
                  atmr = 0;
                  avg_on = 1;
                end
                push(speed, 0, ph);
              end
            end
            PH_AVERAGE: if (atmr > aticks) begin
              ph = PH_CONTROL;
              ref_hd = avg_hd;
            end
            default: push(speed, 12'(turn_for_error()), PH_CONTROL);
          endcase
        end
        MODE_HEADING: take_heading(r.heading);
        MODE_FIX: fix = r.fix;
        MODE_SENSOR: if (r.sensor & 8'h06) begin
          ph = PH_IDLE;
          push(0, 0, PH_IDLE);
        end
        MODE_START: begin
          dtmr = 0;
          pend = 1;
        end
        MODE_STOP: begin
          ph = PH_IDLE;
          avg_on = 0;
          push(0, 0, PH_IDLE);
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t act);
      result_t exp_r;
      results++;
      if (cmd_q.size() == 0) begin
        $display("%0t: unexpected result speed=%0d turn=%0d phase=%0d", $realtime,
                 act.speed_cmd, act.turn_cmd, act.phase);
        errors++;
        return;
      end
      exp_r = cmd_q.pop_front();
      if (act.speed_cmd !== exp_r.speed_cmd) begin
        $display("%0t: speed_cmd expected %0d actual %0d", $realtime,
                 exp_r.speed_cmd, act.speed_cmd);
        errors++;
      end
      if (act.turn_cmd !== exp_r.turn_cmd) begin
        $display("%0t: turn_cmd expected %0d actual %0d", $realtime,
                 exp_r.turn_cmd, act.turn_cmd);
        errors++;
      end
      if (act.phase !== exp_r.phase) begin
        $display("%0t: phase expected %0d actual %0d", $realtime,
                 exp_r.phase, act.phase);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  ghh_in_if  in_ch();
  ghh_out_if out_ch();
  ghh_cfg_if cfg();

  gps_heading_hold_steering_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  steer_scoreboard sb;
  bit calm;
  bit stall_on;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $display("timeout");
    $finish;
  end

  // result side: random stall bursts, sampling at the rising edge
  initial begin
    int n;
    out_ch.ready = 0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 0;
        n = $urandom_range(1, 13);
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready = 1;
        n = $urandom_range(1, 20);
        repeat (n) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      r.speed_cmd = out_ch.speed_cmd;
      r.turn_cmd = out_ch.turn_cmd;
      r.phase = out_ch.phase;
      sb.check_result(r);
    end
  end

  // valid stays high after a request so that the next one can follow at once
  task automatic send_req(steer_req_t r);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 0;
      n = $urandom_range(1, 13);
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.mode <= r.mode;
    in_ch.heading_cdeg <= r.heading;
    in_ch.fix_quality <= r.fix;
    in_ch.sensor_bits <= r.sensor;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_event(mode_t m, logic [16:0] hd = 0, logic [3:0] fq = 1,
                            logic [7:0] sb_bits = 0);
    steer_req_t r;
    r.mode = m;
    r.heading = hd;
    r.fix = fq;
    r.sensor = sb_bits;
    send_req(r);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.cmd_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_profile(logic [15:0] g, logic [15:0] dd, logic [15:0] at,
                             logic [11:0] sp, logic [10:0] lim);
    drain();
    write_reg(REG_GAIN, g);
    write_reg(REG_DDELAY, dd);
    write_reg(REG_ATICKS, at);
    write_reg(REG_SPEED, {4'h0, sp});
    write_reg(REG_LIMIT, {5'h0, lim});
    cfg.valid <= 0;
  endtask

  task automatic random_heading();
    logic [16:0] h;
    case ($urandom_range(0, 5))
      0: h = $urandom_range(0, 131071);
      1: h = $urandom_range(35900, 36100);
      2: h = $urandom_range(0, 200);
      default: h = $urandom_range(0, 36000);
    endcase
    send_event(MODE_HEADING, h);
  endtask

  // one mission: start, drive, average, control, then a halt of some kind
  task automatic run_mission(int unsigned dd, int unsigned at);
    int unsigned k, ctl;
    int base;
    send_event(MODE_FIX, 0, ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd1);
    send_event(MODE_START);
    base = $urandom_range(0, 36000);
    for (k = 0; k < dd + at + 4; k++) begin
      send_event(MODE_TICK);
      if ($urandom_range(0, 1))
        send_event(MODE_HEADING, 17'((base + $urandom_range(0, 4000) - 2000 + 36000) % 36000));
    end
    ctl = $urandom_range(2, 10);
    for (k = 0; k < ctl; k++) begin
      if ($urandom_range(0, 1)) random_heading();
      send_event(MODE_TICK);
    end
    case ($urandom_range(0, 3))
      0: send_event(MODE_SENSOR, 0, 0, 8'($urandom) | 8'h04);
      1: send_event(MODE_SENSOR, 0, 0, 8'($urandom) | 8'h02);
      2: send_event(MODE_SENSOR, 0, 0, 8'($urandom) & 8'hF9);
      default: send_event(MODE_STOP);
    endcase
    send_event(MODE_STOP);
  endtask

  task automatic random_noise();
    steer_req_t r;
    r.mode = mode_t'($urandom_range(0, 7));
    r.heading = 17'($urandom);
    r.fix = 4'($urandom);
    r.sensor = 8'($urandom);
    send_req(r);
  endtask

  initial begin
    int unsigned sent;
    sb = new();
    sb.init();
    calm = 0;
    rst = 1;
    in_ch.valid = 0;
    in_ch.mode = 0;
    in_ch.heading_cdeg = 0;
    in_ch.fix_quality = 0;
    in_ch.sensor_bits = 0;
    cfg.valid = 0;
    cfg.index = 0;
    cfg.data = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: every event, field extremes, fix loss in drive
    send_event(MODE_TICK);
    send_event(MODE_HEADING, 17'h1FFFF);
    send_event(MODE_HEADING, 36000);
    send_event(MODE_HEADING, 36001);
    send_event(MODE_FIX, 0, 4'hF);
    send_event(MODE_SENSOR, 0, 0, 8'hF9);
    send_event(MODE_SENSOR, 0, 0, 8'hFF);
    send_event(MODE_STOP);
    send_event(MODE_TICK, 0, 0, 0);
    send_req('{mode_t'(3'd6), 17'h1FFFF, 4'hF, 8'hFF});
    send_req('{mode_t'(3'd7), 17'h0, 4'h0, 8'h06});
    set_profile(16'hFFFF, 0, 0, 12'h400, 11'd1024);
    send_event(MODE_FIX, 0, 4'd2);
    send_event(MODE_START);
    send_event(MODE_TICK);
    send_event(MODE_TICK);
    run_mission(0, 0);
    set_profile(16'hFFFF, 1, 2, 12'hC00, 11'd0);
    run_mission(1, 2);
    set_profile(0, 3, 1, 12'h000, 11'd1024);
    run_mission(3, 1);

    // pause until all outstanding results are in
    drain();

    sent = sb.steps;
    while (sent < 1250) begin
      if ($urandom_range(0, 9) == 0) begin
        set_profile(16'($urandom), $urandom_range(0, 6), $urandom_range(0, 6),
                    12'($urandom_range(0, 2048) - 1024), 11'($urandom_range(0, 1024)));
      end
      if ($urandom_range(0, 4) != 0) begin
        run_mission(sb.ddelay, sb.aticks);
      end else begin
        repeat (8) random_noise();
      end
      sent = sb.steps;
      if (sent > 1000) calm = 1;
    end

    drain();
    $display("covered %0d requests and %0d results over several gain/delay/limit profiles",
             sb.steps, sb.results);
    if (sb.errors == 0 && sb.cmd_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
